// ===== src/tween_progress_timer_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef TWEEN_PROGRESS_TIMER_ASSERT_SVH
`define TWEEN_PROGRESS_TIMER_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define TPT_ASSERT_NEXT(lbl, ck, rn, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (b)) \
		else $error("tween progress timer check failed");

// The consequent must hold in the same cycle as the antecedent.
`define TPT_ASSERT_NOW(lbl, ck, rn, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (b)) \
		else $error("tween progress timer check failed");

`endif

// ===== src/tpt_pkg.sv =====
package tpt_pkg;

	localparam int TIME_BITS       = 24;
	localparam int ALPHA_FRAC_BITS = 16;
	localparam int CNT_W           = TIME_BITS + 2;
	localparam int RUN_W           = TIME_BITS + 1;
	localparam int DIV_W           = (CNT_W > ALPHA_FRAC_BITS) ? CNT_W : ALPHA_FRAC_BITS;
	localparam int STEP_W          = $clog2(DIV_W + 1);
	localparam int ALPHA_W         = ALPHA_FRAC_BITS + 1;
	localparam int SCL_W           = 24;
	localparam int PROD_W          = TIME_BITS + 8;
	localparam int CFG_W           = (TIME_BITS > 16) ? TIME_BITS : 16;
	localparam int CFG_IDX_W       = 3;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_FWD    = 3'd1,
		OP_BACK   = 3'd2,
		OP_RBEG   = 3'd3,
		OP_REND   = 3'd4,
		OP_PAUSE  = 3'd5,
		OP_RESUME = 3'd6,
		OP_STOP   = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		REG_DURATION = 3'd0,
		REG_DELAY    = 3'd1,
		REG_REPEAT   = 3'd2,
		REG_INTERVAL = 3'd3,
		REG_SPEED    = 3'd4,
		REG_STYLE    = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		STYLE_ONCE = 2'd0,
		STYLE_LOOP = 2'd1,
		STYLE_PING = 2'd2
	} style_t;

	typedef enum logic [1:0] {
		DIV_BODY     = 2'd0,
		DIV_MOD      = 2'd1,
		DIV_RATIO_TD = 2'd2,
		DIV_RATIO_SB = 2'd3
	} div_kind_t;

	typedef enum logic [1:0] {
		TIM_KEEP = 2'd0,
		TIM_SUB  = 2'd1,
		TIM_FLIP = 2'd2,
		TIM_LOAD = 2'd3
	} tim_op_t;

	typedef enum logic [1:0] {
		GB_KEEP = 2'd0,
		GB_CLR  = 2'd1,
		GB_SET  = 2'd2,
		GB_TOG  = 2'd3
	} gb_op_t;

	typedef enum logic [1:0] {
		RUN_KEEP = 2'd0,
		RUN_SET  = 2'd1,
		RUN_CLR  = 2'd2
	} run_op_t;

	typedef enum logic [2:0] {
		RES_NONE = 3'd0,
		RES_DIR  = 3'd1,
		RES_TICK = 3'd2,
		RES_STOP = 3'd3,
		RES_FIN  = 3'd4
	} res_op_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] delta_time;
	} tpt_in_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic               alpha_valid;
		logic               finished;
		logic               playing;
		logic               backward;
		logic               last;
	} tpt_out_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic               valid;
		logic               fin;
	} tpt_res_t;

	typedef struct packed {
		logic      load_in;
		logic      mul;
		logic      res_clear;
		logic      dly_sub;
		tim_op_t   tim_op;
		gb_op_t    gb_op;
		logic      set_prime;
		run_op_t   run_op;
		logic      div_start;
		div_kind_t div_kind;
		res_op_t   res_op;
		logic      emit;
	} tpt_cmd_t;

	typedef struct packed {
		op_t    op;
		style_t style;
		logic   running;
		logic   going_back;
		logic   primed;
		logic   delay_pos;
		logic   time_neg;
		logic   rep_gt1;
		logic   run_bad;
		logic   single_gt_body;
		logic   div_done;
	} tpt_stat_t;

endpackage

// ===== src/tpt_div.sv =====
module tpt_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tpt_pkg::DIV_W-1:0]  dividend,
	input  logic [tpt_pkg::RUN_W-1:0]  divisor,
	input  logic [tpt_pkg::RUN_W-1:0]  rem_init,
	input  logic [tpt_pkg::STEP_W-1:0] steps,
	output logic                       done,
	output logic [tpt_pkg::DIV_W-1:0]  quot,
	output logic [tpt_pkg::RUN_W-1:0]  rem
);
	import tpt_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIV_W-1:0]  dvd_q;
	logic [RUN_W-1:0]  dvs_q;
	logic [RUN_W-1:0]  rem_q;
	logic [RUN_W:0]    rem_sh;
	logic [RUN_W:0]    rem_sub;
	logic              ge;

	// One quotient bit per cycle, restoring.
	assign rem_sh  = {rem_q, dvd_q[DIV_W-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == STEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= rem_init;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub[RUN_W-1:0] : rem_sh[RUN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q;

endmodule

// ===== src/tpt_dpath.sv =====
module tpt_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tpt_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [tpt_pkg::CFG_W-1:0]     cfg_wdata,
	input  tpt_pkg::tpt_in_t              in_data,
	input  tpt_pkg::tpt_cmd_t             cmd,
	output tpt_pkg::tpt_stat_t            stat,
	output tpt_pkg::tpt_res_t             res0,
	output tpt_pkg::tpt_res_t             res1,
	output logic [1:0]                    res_cnt,
	output logic                          running,
	output logic                          going_back
);
	import tpt_pkg::*;

	logic [TIME_BITS-1:0] duration_q;
	logic [TIME_BITS-1:0] delay_cfg_q;
	logic [7:0]           repeat_q;
	logic [TIME_BITS-1:0] interval_q;
	logic [15:0]          speed_q;
	logic [1:0]           style_q;

	logic [2:0]           op_q;
	logic [15:0]          dt_q;
	logic [SCL_W-1:0]     scaled_s1;
	logic [PROD_W-1:0]    prod_s1;

	logic [CNT_W-1:0]     time_left_q;
	logic [CNT_W-1:0]     delay_left_q;
	logic [RUN_W-1:0]     run_len_q;
	logic                 running_q;
	logic                 gb_q;
	logic                 primed_q;
	logic [RUN_W-1:0]     single_q;
	logic [ALPHA_W-1:0]   ratio_q;
	logic                 clamp_q;
	div_kind_t            kind_q;
	tpt_res_t             res_q [2];
	logic [1:0]           rn_q;

	logic [TIME_BITS-1:0] d_eff;
	logic [7:0]           r_eff;
	logic [31:0]          sp_prod;
	logic [PROD_W-1:0]    rp_prod;
	logic                 num_pos;
	logic [TIME_BITS-1:0] num_val;
	logic [CNT_W-1:0]     scaled_c;
	logic [CNT_W-1:0]     abs_t;
	logic [RUN_W:0]       body_w;
	logic                 t_neg;
	logic                 gb_next;
	logic [ALPHA_W-1:0]   tick_alpha;

	logic [DIV_W-1:0]     div_dvd;
	logic [RUN_W-1:0]     div_dvs;
	logic [RUN_W-1:0]     div_rem0;
	logic [STEP_W-1:0]    div_steps;
	logic                 clamp_c;
	logic [ALPHA_W-1:0]   clamp_val;
	logic                 div_done;
	logic [DIV_W-1:0]     div_quot;
	logic [RUN_W-1:0]     div_rem;

	assign d_eff    = (duration_q == '0) ? TIME_BITS'(1) : duration_q;
	assign r_eff    = (repeat_q == 8'd0) ? 8'd1 : repeat_q;
	assign sp_prod  = speed_q * dt_q;
	assign rp_prod  = PROD_W'(r_eff - 8'd1) * PROD_W'(interval_q);
	assign num_pos  = PROD_W'(d_eff) > prod_s1;
	assign num_val  = d_eff - prod_s1[TIME_BITS-1:0];
	assign scaled_c = CNT_W'(scaled_s1);
	assign t_neg    = time_left_q[CNT_W-1];
	assign abs_t    = t_neg ? (~time_left_q + CNT_W'(1)) : time_left_q;
	assign body_w   = {1'b0, run_len_q} - (RUN_W+1)'(interval_q);

	always_comb begin
		case (cmd.gb_op)
			GB_CLR:  gb_next = 1'b0;
			GB_SET:  gb_next = 1'b1;
			GB_TOG:  gb_next = ~gb_q;
			default: gb_next = gb_q;
		endcase
	end

	assign tick_alpha = gb_q ? ratio_q : (ALPHA_ONE - ratio_q);

	always_comb begin
		div_dvd   = '0;
		div_dvs   = '0;
		div_rem0  = '0;
		div_steps = STEP_W'(DIV_W);
		clamp_c   = 1'b0;
		clamp_val = '0;
		case (cmd.div_kind)
			DIV_BODY: begin
				div_dvd = DIV_W'(num_val);
				div_dvs = RUN_W'(r_eff);
			end
			DIV_MOD: begin
				div_dvd = DIV_W'(abs_t);
				div_dvs = run_len_q;
			end
			DIV_RATIO_TD: begin
				div_dvs   = RUN_W'(d_eff);
				div_rem0  = time_left_q[RUN_W-1:0];
				div_steps = STEP_W'(ALPHA_FRAC_BITS);
				if (t_neg || time_left_q == '0) begin
					clamp_c = 1'b1;
				end else if (time_left_q >= CNT_W'(d_eff)) begin
					clamp_c   = 1'b1;
					clamp_val = ALPHA_ONE;
				end
			end
			DIV_RATIO_SB: begin
				div_dvs   = body_w[RUN_W-1:0];
				div_rem0  = single_q;
				div_steps = STEP_W'(ALPHA_FRAC_BITS);
				if (single_q == '0) begin
					clamp_c = 1'b1;
				end else if ({1'b0, single_q} >= body_w) begin
					clamp_c   = 1'b1;
					clamp_val = ALPHA_ONE;
				end
			end
			default: ;
		endcase
	end

	tpt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.rem_init (div_rem0),
		.steps    (div_steps),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q  <= TIME_BITS'(1000);
			delay_cfg_q <= '0;
			repeat_q    <= 8'd1;
			interval_q  <= '0;
			speed_q     <= 16'd256;
			style_q     <= STYLE_ONCE;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_DURATION: duration_q  <= cfg_wdata[TIME_BITS-1:0];
				REG_DELAY:    delay_cfg_q <= cfg_wdata[TIME_BITS-1:0];
				REG_REPEAT:   repeat_q    <= cfg_wdata[7:0];
				REG_INTERVAL: interval_q  <= cfg_wdata[TIME_BITS-1:0];
				REG_SPEED:    speed_q     <= cfg_wdata[15:0];
				REG_STYLE:    style_q     <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= in_data.operation;
			dt_q <= in_data.delta_time;
		end
		if (cmd.mul) begin
			scaled_s1 <= sp_prod[31:8];
			prod_s1   <= rp_prod;
		end
		if (cmd.div_start) begin
			kind_q  <= cmd.div_kind;
			clamp_q <= clamp_c;
			if (clamp_c) begin
				ratio_q <= clamp_val;
			end
		end
		if (div_done) begin
			case (kind_q)
				DIV_MOD: begin
					if (t_neg && div_rem != '0) begin
						single_q <= run_len_q - div_rem;
					end else begin
						single_q <= div_rem;
					end
				end
				DIV_RATIO_TD, DIV_RATIO_SB: begin
					if (!clamp_q) begin
						ratio_q <= ALPHA_W'(div_quot[ALPHA_FRAC_BITS-1:0]);
					end
				end
				default: ;
			endcase
		end
		case (cmd.res_op)
			RES_DIR: begin
				if (rn_q != 2'd2) begin
					res_q[rn_q[0]] <= '{alpha: gb_next ? ALPHA_ONE : '0, valid: 1'b1, fin: 1'b0};
				end
			end
			RES_TICK: begin
				if (rn_q != 2'd2) begin
					res_q[rn_q[0]] <= '{alpha: tick_alpha, valid: 1'b1, fin: 1'b0};
				end
			end
			RES_STOP: begin
				if (rn_q != 2'd2) begin
					res_q[rn_q[0]] <= '{alpha: '0, valid: 1'b0, fin: 1'b1};
				end
			end
			RES_FIN: begin
				if (rn_q == 2'd0) begin
					res_q[0] <= '{alpha: '0, valid: 1'b0, fin: 1'b1};
				end else begin
					res_q[rn_q[0] ^ 1'b1].fin <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_left_q  <= '0;
			delay_left_q <= '0;
			run_len_q    <= '0;
			running_q    <= 1'b0;
			gb_q         <= 1'b0;
			primed_q     <= 1'b0;
			rn_q         <= '0;
		end else begin
			case (cmd.tim_op)
				TIM_SUB:  time_left_q <= time_left_q - scaled_c;
				TIM_FLIP: time_left_q <= CNT_W'(d_eff) - time_left_q;
				TIM_LOAD: begin
					time_left_q  <= CNT_W'(d_eff);
					delay_left_q <= CNT_W'(delay_cfg_q);
				end
				default: ;
			endcase
			if (cmd.dly_sub) begin
				delay_left_q <= delay_left_q - scaled_c;
			end
			gb_q <= gb_next;
			if (cmd.set_prime) begin
				primed_q <= 1'b1;
			end
			case (cmd.run_op)
				RUN_SET: running_q <= 1'b1;
				RUN_CLR: running_q <= 1'b0;
				default: ;
			endcase
			if (div_done && kind_q == DIV_BODY) begin
				run_len_q <= RUN_W'(num_pos ? div_quot[TIME_BITS-1:0] : '0)
					+ RUN_W'(interval_q);
			end
			if (cmd.res_clear) begin
				rn_q <= '0;
			end else begin
				case (cmd.res_op)
					RES_DIR, RES_TICK, RES_STOP: begin
						if (rn_q != 2'd2) begin
							rn_q <= rn_q + 2'd1;
						end
					end
					RES_FIN: begin
						if (rn_q == 2'd0) begin
							rn_q <= 2'd1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign stat.op             = op_t'(op_q);
	assign stat.style          = style_t'(style_q);
	assign stat.running        = running_q;
	assign stat.going_back     = gb_q;
	assign stat.primed         = primed_q;
	assign stat.delay_pos      = !delay_left_q[CNT_W-1] && (delay_left_q != '0);
	assign stat.time_neg       = t_neg;
	assign stat.rep_gt1        = repeat_q > 8'd1;
	assign stat.run_bad        = (run_len_q == '0) || body_w[RUN_W] || (body_w == '0);
	assign stat.single_gt_body = {1'b0, single_q} > body_w;
	assign stat.div_done       = div_done;

	assign res0       = res_q[0];
	assign res1       = res_q[1];
	assign res_cnt    = rn_q;
	assign running    = running_q;
	assign going_back = gb_q;

endmodule

// ===== src/tpt_ctrl.sv =====
module tpt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               obuf_empty,
	input  tpt_pkg::tpt_stat_t stat,
	output tpt_pkg::tpt_cmd_t  cmd
);
	import tpt_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_MUL  = 11'b00000000010,
		S_DEC  = 11'b00000000100,
		S_T1   = 11'b00000001000,
		S_RATW = 11'b00000010000,
		S_MODW = 11'b00000100000,
		S_CHK  = 11'b00001000000,
		S_ADD  = 11'b00010000000,
		S_END  = 11'b00100000000,
		S_RUNW = 11'b01000000000,
		S_EMIT = 11'b10000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul       = 1'b1;
				cmd.res_clear = 1'b1;
				state_d       = S_DEC;
			end
			S_DEC: begin
				state_d = S_EMIT;
				case (stat.op)
					OP_TICK: begin
						if (stat.running) begin
							if (stat.delay_pos) begin
								cmd.dly_sub = 1'b1;
							end else begin
								cmd.tim_op = TIM_SUB;
								state_d    = S_T1;
							end
						end
					end
					OP_FWD, OP_BACK: begin
						if (!stat.primed) begin
							cmd.tim_op    = TIM_LOAD;
							cmd.set_prime = 1'b1;
							cmd.res_op    = RES_DIR;
						end else if (stat.going_back == (stat.op == OP_FWD)) begin
							cmd.tim_op = TIM_FLIP;
						end
						cmd.gb_op     = (stat.op == OP_FWD) ? GB_CLR : GB_SET;
						cmd.run_op    = RUN_SET;
						cmd.div_start = 1'b1;
						cmd.div_kind  = DIV_BODY;
						state_d       = S_RUNW;
					end
					OP_RBEG, OP_REND: begin
						cmd.tim_op    = TIM_LOAD;
						cmd.set_prime = 1'b1;
						cmd.res_op    = RES_DIR;
						cmd.gb_op     = (stat.op == OP_RBEG) ? GB_CLR : GB_SET;
					end
					OP_PAUSE:  cmd.run_op = RUN_CLR;
					OP_RESUME: cmd.run_op = RUN_SET;
					OP_STOP: begin
						cmd.run_op = RUN_CLR;
						cmd.res_op = RES_STOP;
					end
					default: ;
				endcase
			end
			S_T1: begin
				if (stat.rep_gt1) begin
					if (stat.run_bad) begin
						state_d = S_END;
					end else begin
						cmd.div_start = 1'b1;
						cmd.div_kind  = DIV_MOD;
						state_d       = S_MODW;
					end
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_kind  = DIV_RATIO_TD;
					state_d       = S_RATW;
				end
			end
			S_RATW: begin
				if (stat.div_done) begin
					state_d = S_ADD;
				end
			end
			S_MODW: begin
				if (stat.div_done) begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.single_gt_body) begin
					state_d = S_END;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_kind  = DIV_RATIO_SB;
					state_d       = S_RATW;
				end
			end
			S_ADD: begin
				cmd.res_op = RES_TICK;
				state_d    = S_END;
			end
			S_END: begin
				state_d = S_EMIT;
				if (stat.time_neg) begin
					if (stat.style == STYLE_LOOP || stat.style == STYLE_PING) begin
						cmd.tim_op    = TIM_LOAD;
						cmd.gb_op     = (stat.style == STYLE_PING) ? GB_TOG : GB_KEEP;
						cmd.set_prime = 1'b1;
						cmd.res_op    = RES_DIR;
						cmd.run_op    = RUN_SET;
						cmd.div_start = 1'b1;
						cmd.div_kind  = DIV_BODY;
						state_d       = S_RUNW;
					end else begin
						cmd.run_op = RUN_CLR;
						cmd.res_op = RES_FIN;
					end
				end
			end
			S_RUNW: begin
				if (stat.div_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (obuf_empty) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

// ===== src/tpt_obuf.sv =====
module tpt_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  tpt_pkg::tpt_res_t res0,
	input  tpt_pkg::tpt_res_t res1,
	input  logic [1:0]        res_cnt,
	input  logic              running,
	input  logic              going_back,
	output logic              empty,
	output logic              out_valid,
	input  logic              out_stall,
	output tpt_pkg::tpt_out_t out_data
);
	import tpt_pkg::*;

	tpt_out_t   slot_q [2];
	logic [1:0] cnt_q;
	logic       two;

	assign two = (res_cnt == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= two ? 2'd2 : 2'd1;
		end else if (out_valid && !out_stall) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (res_cnt == 2'd0) begin
				slot_q[0] <= '{alpha: '0, alpha_valid: 1'b0, finished: 1'b0,
					playing: running, backward: going_back, last: 1'b1};
			end else begin
				slot_q[0] <= '{alpha: res0.valid ? res0.alpha : '0, alpha_valid: res0.valid,
					finished: res0.fin, playing: running, backward: going_back, last: !two};
			end
			slot_q[1] <= '{alpha: res1.valid ? res1.alpha : '0, alpha_valid: res1.valid,
				finished: res1.fin, playing: running, backward: going_back, last: 1'b1};
		end else if (out_valid && !out_stall) begin
			slot_q[0] <= slot_q[1];
		end
	end

	assign empty     = (cnt_q == 2'd0);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot_q[0];

endmodule

// ===== src/tween_progress_timer.sv =====
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  tpt_in_t: operation, delta_time
// out      output     out_valid/out_stall tpt_out_t: alpha, flags, last
// cfg      input      cfg_we             cfg_idx, cfg_wdata
//
// Commands without division pass through the multiply, decode and emit states.
// Play and a restart add one run length division. A tick that counts down the duration
// adds a ratio division, or with several repeats a modulo division before it; all go
// through one shared bit-serial divider.
// Reset is asynchronous and leaves the engine stopped with default registers.
// One transaction is accepted at a time; up to two results wait in the output buffer.
module tween_progress_timer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  tpt_pkg::tpt_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output tpt_pkg::tpt_out_t             out_data,
	input  logic                          cfg_we,
	input  logic [tpt_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [tpt_pkg::CFG_W-1:0]     cfg_wdata
);
	import tpt_pkg::*;

	tpt_cmd_t   cmd;
	tpt_stat_t  stat;
	tpt_res_t   res0;
	tpt_res_t   res1;
	logic [1:0] res_cnt;
	logic       running;
	logic       going_back;
	logic       obuf_empty;

	tpt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.obuf_empty (obuf_empty),
		.stat       (stat),
		.cmd        (cmd)
	);

	tpt_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.in_data    (in_data),
		.cmd        (cmd),
		.stat       (stat),
		.res0       (res0),
		.res1       (res1),
		.res_cnt    (res_cnt),
		.running    (running),
		.going_back (going_back)
	);

	tpt_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (cmd.emit),
		.res0       (res0),
		.res1       (res1),
		.res_cnt    (res_cnt),
		.running    (running),
		.going_back (going_back),
		.empty      (obuf_empty),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

// ===== src/tpt_chk.sv =====
`include "tween_progress_timer_assert.svh"

module tpt_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input tpt_pkg::tpt_out_t out_data
);
	import tpt_pkg::*;

	`TPT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	`TPT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	`TPT_ASSERT_NEXT(a_second_ready, clk, arst_n, out_valid && !out_stall && !out_data.last, out_valid)
	`TPT_ASSERT_NOW(a_fin_on_last, clk, arst_n, out_valid && out_data.finished, out_data.last)

endmodule

bind tween_progress_timer tpt_chk u_tpt_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
